// ===== src/tccc_pkg.sv =====
// ----------------------------------------------------------------------------
// tccc_pkg
// types and constants shared by the text console cursor controller
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

  // field widths
  localparam int CELL_W    = 8;
  localparam int PIXEL_X_W = 12;
  localparam int PIXEL_Y_W = 13;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 3;

  // operations on the input channel
  localparam logic OP_PUT_CHAR     = 1'b0;
  localparam logic OP_CLEAR_SCREEN = 1'b1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd4;

  // register reset values
  localparam logic [CELL_W-1:0]  TEXT_COLS_RESET  = 8'd1;
  localparam logic [CELL_W-1:0]  TEXT_ROWS_RESET  = 8'd1;
  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 32'h0015_1530;

  // control characters and the printable range
  localparam logic [7:0] CHAR_BS        = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_PRINT_LO  = 8'd32;
  localparam logic [7:0] CHAR_PRINT_HI  = 8'd126;
  localparam logic [8:0] TAB_STOP       = 9'd4;
  localparam logic [8:0] TAB_MASK       = ~9'd3;

  typedef enum logic [1:0] {
    CMD_DRAW_GLYPH   = 2'd0,
    CMD_CLEAR_CELL   = 2'd1,
    CMD_SCROLL_UP    = 2'd2,
    CMD_CLEAR_SCREEN = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                enabled;
    logic [CELL_W-1:0]   text_cols;
    logic [CELL_W-1:0]   text_rows;
    logic [COLOR_W-1:0]  foreground;
    logic [COLOR_W-1:0]  background;
  } cfg_t;

  // one classified character: an optional cell command and an optional scroll
  typedef struct packed {
    logic               cell_valid;
    cmd_t               cell_cmd;
    logic [CELL_W-1:0]  cell_col;
    logic [CELL_W-1:0]  cell_row;
    logic [7:0]         glyph;
    logic               scroll_valid;
    logic [CELL_W-1:0]  bottom;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/tccc_front.sv =====
// ----------------------------------------------------------------------------
// tccc_front
// accepts characters, keeps the cursor and classifies each into queue entries
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_front
  import tccc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic              operation,
  input  wire logic [7:0]        char_code,
  output logic                   push,
  output entry_t                 push_entry
);

  logic [CELL_W-1:0] cursor_col;
  logic [CELL_W-1:0] cursor_row;
  logic [CELL_W:0]   col_next;
  logic [CELL_W:0]   row_next;
  logic [CELL_W:0]   cols;
  logic [CELL_W:0]   rows;
  entry_t            ent;

  always_comb begin
    cols = (cfg.text_cols == '0) ? 9'd1 : {1'b0, cfg.text_cols};
    rows = (cfg.text_rows == '0) ? 9'd1 : {1'b0, cfg.text_rows};
    col_next = {1'b0, cursor_col};
    row_next = {1'b0, cursor_row};
    ent = '0;
    ent.cell_cmd = CMD_DRAW_GLYPH;
    ent.cell_col = cursor_col;
    ent.cell_row = cursor_row;
    if (operation == OP_CLEAR_SCREEN) begin
      col_next = '0;
      row_next = '0;
      ent.cell_valid = 1'b1;
      ent.cell_cmd = CMD_CLEAR_SCREEN;
      ent.cell_col = '0;
      ent.cell_row = '0;
    end else begin
      case (char_code)
        CHAR_LF: begin
          col_next = '0;
          row_next = row_next + 9'd1;
        end
        CHAR_CR: begin
          col_next = '0;
        end
        CHAR_TAB: begin
          col_next = (col_next + TAB_STOP) & TAB_MASK;
        end
        CHAR_BS: begin
          if (cursor_col != '0) begin
            col_next = col_next - 9'd1;
            ent.cell_valid = 1'b1;
            ent.cell_cmd = CMD_CLEAR_CELL;
            ent.cell_col = col_next[CELL_W-1:0];
          end
        end
        default: begin
          if (char_code >= CHAR_PRINT_LO && char_code <= CHAR_PRINT_HI) begin
            ent.cell_valid = 1'b1;
            ent.glyph = char_code;
            col_next = col_next + 9'd1;
          end
        end
      endcase
      // wrap at the right edge
      if (col_next >= cols) begin
        col_next = '0;
        row_next = row_next + 9'd1;
      end
      // single scroll at the bottom
      if (row_next >= rows) begin
        ent.scroll_valid = 1'b1;
        row_next = rows - 9'd1;
        ent.bottom = row_next[CELL_W-1:0];
      end
    end
  end

  assign push       = accept && cfg.enabled && (ent.cell_valid || ent.scroll_valid);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept && cfg.enabled) begin
      cursor_col <= col_next[CELL_W-1:0];
      cursor_row <= row_next[CELL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/tccc_queue.sv =====
// ----------------------------------------------------------------------------
// tccc_queue
// short first-in first-out queue of classified entries
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_queue
  import tccc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        head_valid,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  entry_t            entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == DEPTH_CNT);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/tccc_back.sv =====
// ----------------------------------------------------------------------------
// tccc_back
// expands queue entries into drawing commands with pixel origins
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_back
  import tccc_pkg::*;
#(
  parameter int GLYPH_WIDTH  = 9,
  parameter int GLYPH_HEIGHT = 18,
  parameter int MARGIN       = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire entry_t                head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 command,
  output logic [CELL_W-1:0]          cell_col,
  output logic [CELL_W-1:0]          cell_row,
  output logic [PIXEL_X_W-1:0]       pixel_x,
  output logic [PIXEL_Y_W-1:0]       pixel_y,
  output logic [7:0]                 glyph_code,
  output logic [COLOR_W-1:0]         fore_color,
  output logic [COLOR_W-1:0]         back_color,
  output logic                       last
);

  logic               phase;
  logic               load;
  logic               use_cell;
  cmd_t               sel_cmd;
  logic [CELL_W-1:0]  sel_col;
  logic [CELL_W-1:0]  sel_row;
  logic [7:0]         sel_glyph;
  logic               sel_last;
  logic [31:0]        px_full;
  logic [31:0]        py_full;

  assign load     = head_valid && (!out_valid || !out_stall);
  assign use_cell = head.cell_valid && !phase;
  // a cell command followed by a scroll keeps the entry until its scroll is loaded
  assign pop      = load && !(use_cell && head.scroll_valid);

  always_comb begin
    if (use_cell) begin
      sel_cmd   = head.cell_cmd;
      sel_col   = head.cell_col;
      sel_row   = head.cell_row;
      sel_glyph = head.glyph;
      sel_last  = !head.scroll_valid;
    end else begin
      sel_cmd   = CMD_SCROLL_UP;
      sel_col   = '0;
      sel_row   = head.bottom;
      sel_glyph = '0;
      sel_last  = 1'b1;
    end
    px_full = 32'(MARGIN) + 32'(sel_col) * 32'(GLYPH_WIDTH);
    py_full = 32'(MARGIN) + 32'(sel_row) * 32'(GLYPH_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase <= !pop;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command    <= sel_cmd;
      cell_col   <= sel_col;
      cell_row   <= sel_row;
      glyph_code <= sel_glyph;
      last       <= sel_last;
      fore_color <= cfg.foreground;
      back_color <= cfg.background;
      if (sel_cmd == CMD_CLEAR_SCREEN) begin
        pixel_x <= '0;
        pixel_y <= '0;
      end else begin
        pixel_x <= px_full[PIXEL_X_W-1:0];
        pixel_y <= py_full[PIXEL_Y_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_cursor_control.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_control
// text cursor keeper that turns characters into cell drawing commands
// ----------------------------------------------------------------------------
// Each accepted transaction is a character or a clear-screen request. The
// front stage classifies it in the cycle it is accepted, updates the cursor
// and queues at most one entry; a character can be taken every cycle while
// the queue has room. The back stage turns each entry into one or two
// commands, one per cycle through a single output register while out_stall
// is low, so a character that draws or clears a cell and also scrolls
// gives two commands and any other character one (or none, for ignored
// codes and cursor moves that give no command). While enabled is low every
// transaction is accepted and dropped. Configuration registers are written
// through cfg_write / cfg_index / cfg_data with no read-back and should
// only change while no commands are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_control
  import tccc_pkg::*;
#(
  parameter int GLYPH_WIDTH  = 9,
  parameter int GLYPH_HEIGHT = 18,
  parameter int MARGIN       = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COLOR_W-1:0]    cfg_data,
  // character input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [7:0]            char_code,
  // command output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 command,
  output logic [CELL_W-1:0]          cell_col,
  output logic [CELL_W-1:0]          cell_row,
  output logic [PIXEL_X_W-1:0]       pixel_x,
  output logic [PIXEL_Y_W-1:0]       pixel_y,
  output logic [7:0]                 glyph_code,
  output logic [COLOR_W-1:0]         fore_color,
  output logic [COLOR_W-1:0]         back_color,
  output logic                       last
);

  cfg_t    cfg;
  logic    in_accept;
  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;
  logic    head_valid;
  logic    full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled    <= 1'b0;
      cfg.text_cols  <= TEXT_COLS_RESET;
      cfg.text_rows  <= TEXT_ROWS_RESET;
      cfg.foreground <= FOREGROUND_RESET;
      cfg.background <= BACKGROUND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLED:    cfg.enabled    <= cfg_data[0];
        REG_TEXT_COLS:  cfg.text_cols  <= cfg_data[CELL_W-1:0];
        REG_TEXT_ROWS:  cfg.text_rows  <= cfg_data[CELL_W-1:0];
        REG_FOREGROUND: cfg.foreground <= cfg_data;
        REG_BACKGROUND: cfg.background <= cfg_data;
        default:        cfg <= cfg;
      endcase
    end
  end

  // input stalls only when the queue has no room
  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  tccc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (in_accept),
    .operation  (operation),
    .char_code  (char_code),
    .push       (push),
    .push_entry (push_entry)
  );

  tccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  tccc_back #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .MARGIN       (MARGIN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .glyph_code (glyph_code),
    .fore_color (fore_color),
    .back_color (back_color),
    .last       (last)
  );

  // a scroll or a clear screen always ends its transaction
  a_scroll_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_SCROLL_UP || command == CMD_CLEAR_SCREEN) |-> last)
    else $error("scroll or clear screen not marked last");

  // clear screen starts at the framebuffer origin
  a_clear_origin : assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_CLEAR_SCREEN |-> pixel_x == '0 && pixel_y == '0)
    else $error("clear screen with non-zero origin");

  // only printable codes are drawn
  a_glyph_printable : assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_DRAW_GLYPH
      |-> glyph_code >= CHAR_PRINT_LO && glyph_code <= CHAR_PRINT_HI)
    else $error("glyph command carries an unprintable code");

  // a non-final command is always followed by the scroll of the same character
  a_pair_order : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && command == CMD_SCROLL_UP)
    else $error("first command of a pair not followed by its scroll");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text console cursor controller
// ----------------------------------------------------------------------------
// A queue of characters and clear-screen requests feeds a clocked driver.
// A clocked monitor keeps its own copy of the cursor and the registers. It
// works out the drawing commands of every accepted transaction and checks
// each command that leaves the block against the oldest one still due.
// The run is split into phases of its own register settings and idling.
// ----------------------------------------------------------------------------

module tb_top
  import tccc_pkg::*;
();

  localparam int FONT_W       = 9;
  localparam int FONT_H       = 18;
  localparam int MARGIN_PX    = 16;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 24;      // time for the entry queue to drain
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // one drawing command as seen on the output channel
  typedef struct {
    cmd_t                 cmd;
    logic [CELL_W-1:0]    col;
    logic [CELL_W-1:0]    row;
    logic [PIXEL_X_W-1:0] px;
    logic [PIXEL_Y_W-1:0] py;
    logic [7:0]           glyph;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
    logic                 last_flag;
  } cmd_rec_t;

  // one transaction on the character channel
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } char_item_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 operation = OP_PUT_CHAR;
  logic [7:0]           char_code = 8'd0;
  logic                 out_stall = 1'b0;

  // block outputs
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           command;
  logic [CELL_W-1:0]    cell_col;
  logic [CELL_W-1:0]    cell_row;
  logic [PIXEL_X_W-1:0] pixel_x;
  logic [PIXEL_Y_W-1:0] pixel_y;
  logic [7:0]           glyph_code;
  logic [COLOR_W-1:0]   fore_color;
  logic [COLOR_W-1:0]   back_color;
  logic                 last;

  text_console_cursor_control #(
    .GLYPH_WIDTH  (FONT_W),
    .GLYPH_HEIGHT (FONT_H),
    .MARGIN       (MARGIN_PX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .glyph_code (glyph_code),
    .fore_color (fore_color),
    .back_color (back_color),
    .last       (last)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------

  // our own copy of the registers, written alongside the port
  logic               cfg_enabled = 1'b0;
  logic [CELL_W-1:0]  cfg_cols    = TEXT_COLS_RESET;
  logic [CELL_W-1:0]  cfg_rows    = TEXT_ROWS_RESET;
  logic [COLOR_W-1:0] cfg_fg      = FOREGROUND_RESET;
  logic [COLOR_W-1:0] cfg_bg      = BACKGROUND_RESET;

  // predicted cursor position
  logic [CELL_W-1:0]  cursor_col = '0;
  logic [CELL_W-1:0]  cursor_row = '0;

  char_item_t pending_chars[$];   // waiting for the driver
  cmd_rec_t   commands_due[$];    // predicted, not yet seen on the output

  int  offered_items   = 0;
  int  accepted_items  = 0;
  int  mismatch_count  = 0;
  int  cycle_count     = 0;
  int  send_idle_pct   = 0;
  int  recv_stall_pct  = 0;
  int  hold_requests   = 0;
  int  hold_served     = 0;
  int  hold_left       = 0;
  logic in_taken       = 1'b0;   // the offered transaction went in at the last edge

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // pixel origin is margin plus cell times font size, except for clear screen
  function automatic cmd_rec_t make_cmd(cmd_t c, int col, int row, logic [7:0] glyph,
                                        bit at_origin);
    cmd_rec_t r;
    int       px_full;
    int       py_full;
    px_full     = at_origin ? 0 : MARGIN_PX + col * FONT_W;
    py_full     = at_origin ? 0 : MARGIN_PX + row * FONT_H;
    r.cmd       = c;
    r.col       = col[CELL_W-1:0];
    r.row       = row[CELL_W-1:0];
    r.px        = px_full[PIXEL_X_W-1:0];
    r.py        = py_full[PIXEL_Y_W-1:0];
    r.glyph     = glyph;
    r.fg        = cfg_fg;
    r.bg        = cfg_bg;
    r.last_flag = 1'b0;
    return r;
  endfunction

  // advance the cursor for one character and queue the commands it causes
  task automatic predict_commands(input logic op, input logic [7:0] ch);
    int       cols;
    int       rows;
    int       col;
    int       row;
    int       bottom;
    int       n;
    cmd_rec_t recs[2];
    cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);   // zero size counts as one
    rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
    col  = int'(cursor_col);
    row  = int'(cursor_row);
    n    = 0;
    if (!cfg_enabled)
      return;
    if (op == OP_CLEAR_SCREEN) begin
      col = 0;
      row = 0;
      recs[n] = make_cmd(CMD_CLEAR_SCREEN, 0, 0, 8'd0, 1'b1);
      n++;
    end else begin
      if (ch == CHAR_LF) begin
        col = 0;
        row++;
      end else if (ch == CHAR_CR) begin
        col = 0;
      end else if (ch == CHAR_TAB) begin
        // no width limit here, so a tab past the last stop always wraps
        col = (col + int'(TAB_STOP)) & int'(TAB_MASK);
      end else if (ch == CHAR_BS) begin
        if (col > 0) begin
          col--;
          recs[n] = make_cmd(CMD_CLEAR_CELL, col, row, 8'd0, 1'b0);
          n++;
        end
      end else if (ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI) begin
        recs[n] = make_cmd(CMD_DRAW_GLYPH, col, row, ch, 1'b0);
        n++;
        col++;
      end
      // wrap and scroll run for every character, ignored codes included
      if (col >= cols) begin
        col = 0;
        row++;
      end
      // a single scroll even when the area has shrunk under the cursor
      if (row >= rows) begin
        bottom  = rows - 1;
        recs[n] = make_cmd(CMD_SCROLL_UP, 0, bottom, 8'd0, 1'b0);
        n++;
        row = bottom;
      end
    end
    cursor_col = col[CELL_W-1:0];
    cursor_row = row[CELL_W-1:0];
    for (int i = 0; i < n; i++) begin
      recs[i].last_flag = (i == n - 1);
      commands_due.push_back(recs[i]);
    end
  endtask

  function automatic string show_cmd(cmd_rec_t r);
    return $sformatf("cmd %0d col %0d row %0d x %0d y %0d glyph %02h fg %08h bg %08h last %b",
                     r.cmd, r.col, r.row, r.px, r.py, r.glyph, r.fg, r.bg, r.last_flag);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued characters, changes only at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // the channel is free: offer the next transaction or idle
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        operation <= pending_chars[0].op;
        char_code <= pending_chars[0].ch;
        void'(pending_chars.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    // otherwise the stalled transaction is held as it is
  end

  // long hold-off of the receiver, counted here so the sender is unaffected
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall, random or held
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    cmd_rec_t seen;
    cmd_rec_t want;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predict_commands(operation, char_code);
      accepted_items++;
    end
    if (!rst && out_valid && !out_stall) begin
      seen.cmd       = cmd_t'(command);
      seen.col       = cell_col;
      seen.row       = cell_row;
      seen.px        = pixel_x;
      seen.py        = pixel_y;
      seen.glyph     = glyph_code;
      seen.fg        = fore_color;
      seen.bg        = back_color;
      seen.last_flag = last;
      if (commands_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: command with nothing due: %s", $realtime, show_cmd(seen));
      end else begin
        want = commands_due.pop_front();
        if (seen.cmd !== want.cmd || seen.col !== want.col || seen.row !== want.row ||
            seen.px !== want.px || seen.py !== want.py || seen.glyph !== want.glyph ||
            seen.fg !== want.fg || seen.bg !== want.bg ||
            seen.last_flag !== want.last_flag) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: command mismatch", $realtime);
            $display("  expected %s", show_cmd(want));
            $display("  actual   %s", show_cmd(seen));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_cursor_control regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------

  // one register write per falling edge; end_writes drops the enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ENABLED:    cfg_enabled = data[0];
      REG_TEXT_COLS:  cfg_cols    = data[CELL_W-1:0];
      REG_TEXT_ROWS:  cfg_rows    = data[CELL_W-1:0];
      REG_FOREGROUND: cfg_fg      = data;
      REG_BACKGROUND: cfg_bg      = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [COLOR_W-1:0] cols, input logic [COLOR_W-1:0] rows,
                           input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    write_reg(REG_TEXT_COLS, cols);
    write_reg(REG_TEXT_ROWS, rows);
    write_reg(REG_FOREGROUND, fg);
    write_reg(REG_BACKGROUND, bg);
    end_writes();
  endtask

  // idling is set and the queue filled at a rising edge, away from the driver
  task automatic start_phase(input int send_pct, input int stall_pct, input bit hold);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (hold)
      hold_requests++;
  endtask

  task automatic offer(input logic op, input logic [7:0] ch);
    pending_chars.push_back('{op: op, ch: ch});
    offered_items++;
  endtask

  // mostly printable text (less so when tab heavy) with control codes and the odd stray byte
  task automatic offer_random(input int count, input bit tab_heavy, input bit no_clear);
    int         pick;
    int         tab_top;
    logic [7:0] ch;
    for (int i = 0; i < count; i++) begin
      pick    = $urandom_range(99);
      tab_top = tab_heavy ? 33 : 11;
      ch      = 8'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
      if (!no_clear && pick < 3)
        offer(OP_CLEAR_SCREEN, 8'($urandom_range(255)));
      else if (pick < tab_top)
        offer(OP_PUT_CHAR, CHAR_TAB);
      else if (pick < tab_top + 9)
        offer(OP_PUT_CHAR, CHAR_LF);
      else if (pick < tab_top + 14)
        offer(OP_PUT_CHAR, CHAR_CR);
      else if (pick < tab_top + 24)
        offer(OP_PUT_CHAR, CHAR_BS);
      else if (pick < tab_top + 32)
        offer(OP_PUT_CHAR, 8'($urandom_range(255)));
      else
        offer(OP_PUT_CHAR, ch);
    end
  endtask

  // everything taken and every command seen, then let the entry queue drain
  task automatic wait_idle();
    while (accepted_items != offered_items || commands_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int send_pct, input int stall_pct,
                            input bit hold, input bit tab_heavy, input bit no_clear);
    start_phase(send_pct, stall_pct, hold);
    offer_random(count, tab_heavy, no_clear);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [31:0] rnd;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // switched off: every transaction is taken and dropped
    write_reg(REG_ENABLED, 32'd0);
    end_writes();
    run_random(30, 0, 0, 1'b0, 1'b0, 1'b0);

    // directed: small 8 x 3 area
    write_reg(REG_ENABLED, 32'd1);
    configure(32'd8, 32'd3, 32'h00FF_FFFF, 32'h0015_1530);
    start_phase(0, 0, 1'b0);
    offer(OP_CLEAR_SCREEN, 8'hFF);
    offer(OP_PUT_CHAR, CHAR_PRINT_LO);     // lowest printable
    offer(OP_PUT_CHAR, CHAR_PRINT_HI);     // highest printable
    offer(OP_PUT_CHAR, 8'd31);             // just below printable
    offer(OP_PUT_CHAR, 8'd127);            // just above printable
    offer(OP_PUT_CHAR, 8'd0);
    offer(OP_PUT_CHAR, 8'd255);
    offer(OP_PUT_CHAR, CHAR_BS);           // clears the cell at column 1
    offer(OP_PUT_CHAR, CHAR_BS);           // clears the cell at column 0
    offer(OP_PUT_CHAR, CHAR_BS);           // nothing at column 0
    offer(OP_PUT_CHAR, CHAR_TAB);          // column 4
    offer(OP_PUT_CHAR, "A");
    offer(OP_PUT_CHAR, CHAR_TAB);          // reaches the width, wraps to the next row
    offer(OP_PUT_CHAR, CHAR_CR);
    offer(OP_PUT_CHAR, CHAR_LF);           // bottom row
    offer(OP_PUT_CHAR, CHAR_LF);           // scroll with no cell command
    offer(OP_PUT_CHAR, CHAR_TAB);
    offer(OP_PUT_CHAR, "a");
    offer(OP_PUT_CHAR, "b");
    offer(OP_PUT_CHAR, "c");
    offer(OP_PUT_CHAR, "z");               // draw in the last cell, then scroll
    offer(OP_CLEAR_SCREEN, 8'h00);
    offer(OP_PUT_CHAR, 8'h80);             // top bit alone, ignored
    wait_idle();

    // ordinary terminal, sender idling
    configure(32'd80, 32'd25, 32'h00FF_FFFF, 32'h0015_1530);
    run_random(200, 58, 0, 1'b0, 1'b0, 1'b0);

    // widest area, tab heavy to reach the last tab stop; receiver holds off at first
    configure(32'd255, 32'd255, 32'h0000_0000, 32'hFFFF_FFFF);
    run_random(200, 0, 58, 1'b1, 1'b1, 1'b0);

    // one cell: every glyph also scrolls
    configure(32'd1, 32'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    run_random(150, 29, 29, 1'b0, 1'b0, 1'b0);

    // zero size behaves as one
    configure(32'd0, 32'd0, $urandom, $urandom);
    run_random(100, 0, 0, 1'b0, 1'b0, 1'b0);

    // walk the cursor deep into a large area without clearing
    configure(32'd200, 32'd200, $urandom, $urandom);
    run_random(150, 58, 0, 1'b0, 1'b0, 1'b1);

    // shrink the area under the cursor
    configure(32'd13, 32'd4, $urandom, $urandom);
    run_random(150, 0, 58, 1'b0, 1'b0, 1'b0);

    // random sizes, stray upper bits on the data bus
    for (int p = 0; p < 2; p++) begin
      rnd = $urandom;
      write_reg(REG_ENABLED, {rnd[31:1], 1'b1});
      rnd = $urandom;
      configure({rnd[31:8], 8'($urandom_range(255, 1))},
                {rnd[23:0], 8'($urandom_range(255, 1))}, $urandom, $urandom);
      run_random(75, (p == 0) ? 29 : 0, (p == 0) ? 29 : 0, 1'b0, 1'b0, 1'b0);
    end

    if (mismatch_count == 0)
      $display("text_console_cursor_control regression: pass");
    else
      $display("text_console_cursor_control regression: fail");
    $finish;
  end

endmodule

// ===== text_console_cursor_control.f =====
src/tccc_pkg.sv
src/tccc_front.sv
src/tccc_queue.sv
src/tccc_back.sv
src/text_console_cursor_control.sv
dv/tb_top.sv
